// ===== rtl/core/pdch_pkg.sv =====
// ----------------------------------------------------------------------------
// pdch_pkg
// Shared constants, types and helpers of the pixel difference coder.
// ----------------------------------------------------------------------------
package pdch_pkg;

	// image size limits and register widths
	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int SIZE_W      = 13;
	localparam int POS_W       = 12;

	// histogram geometry
	localparam int COUNT_BITS  = 32;
	localparam int NUM_BINS    = 511;
	localparam int BIN_W       = 9;
	localparam int RAM_DEPTH   = 512;
	localparam int BIN_OFFSET  = 255;
	localparam int CODE_OFFSET = 128;

	// request kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// one item as it leaves the predictor
	typedef struct packed {
		logic                    req;
		logic signed [8:0]       residual;
		logic [7:0]              code;
		logic                    frame_end;
		logic [BIN_W-1:0]        addr;
	} item_t;

	// zero maps to one, anything above the limit maps to the limit
	function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] limit);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = {{(SIZE_W-1){1'b0}}, 1'b1};
		end else if (v > limit) begin
			r = limit;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/pixel_difference_coder_histogram.sv =====
// ----------------------------------------------------------------------------
// pixel_difference_coder_histogram
// Left-neighbour DPCM coder of grey pixels with a saturating residual
// histogram that is read and cleared one bin per request.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat is registered in stage 1 with the RAM read, then
//   moves to the output register, where m_tvalid rises; stage 1 holds on a stall.
// Throughput: one beat per clock unless the output stalls; the histogram RAM does
//   a read and a write-back per beat, the last write forwarded to the next beat.
// Reset: position and prediction state clear at once; the histogram RAM is
//   then zeroed by a clearing pass over all 512 entries, with s_tready low.
// ----------------------------------------------------------------------------
module pixel_difference_coder_histogram (
	input  logic                              clk,
	input  logic                              arst_n,
	// input beats
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,  // pixel_value, bin_index, pad
	input  logic                              s_tuser,  // req_type
	// result beats
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [55:0]                       m_tdata,  // residual, residual_code, bin_count, pad
	output logic                              m_tlast,  // frame_end
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pdch_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdch_pkg::SIZE_W-1:0]       cfg_data
);
	import pdch_pkg::*;

	logic [SIZE_W-1:0]      width_q;
	logic [SIZE_W-1:0]      height_q;
	logic                   pix_accept;
	item_t                  item;
	logic signed [8:0]      residual;
	logic [7:0]             residual_code;
	logic [COUNT_BITS-1:0]  bin_count;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// prediction
	assign pix_accept = s_tvalid && s_tready && (s_tuser == REQ_PIXEL);

	pdch_pred u_pred (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_accept   (pix_accept),
		.req          (s_tuser),
		.pixel_value  (s_tdata[7:0]),
		.bin_index    (s_tdata[16:8]),
		.image_width  (width_q),
		.image_height (height_q),
		.item         (item)
	);

	// histogram and output register
	pdch_hist u_hist (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.item          (item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_residual  (residual),
		.out_code      (residual_code),
		.out_frame_end (m_tlast),
		.out_count     (bin_count)
	);

	// result packing
	assign m_tdata = {7'd0, bin_count, residual_code, residual};

endmodule

// ===== rtl/core/pdch_ram.sv =====
// ----------------------------------------------------------------------------
// pdch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/pdch_pred.sv =====
// ----------------------------------------------------------------------------
// pdch_pred
// Raster position and prediction from the left pixel, or above at row start.
// ----------------------------------------------------------------------------
module pdch_pred (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_accept,
	input  logic                          req,
	input  logic [7:0]                    pixel_value,
	input  logic [pdch_pkg::BIN_W-1:0]    bin_index,
	input  logic [pdch_pkg::SIZE_W-1:0]   image_width,
	input  logic [pdch_pkg::SIZE_W-1:0]   image_height,
	output pdch_pkg::item_t               item
);
	import pdch_pkg::*;

	logic [7:0]        prev_q;
	logic [7:0]        row_start_q;
	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;

	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic              first_col;
	logic              first_row;
	logic [7:0]        pred;
	logic signed [8:0] diff;
	logic signed [8:0] adj;
	logic signed [8:0] half;
	logic              row_end;
	logic              last_row;

	// effective image size
	assign w_eff = effective_size(image_width, SIZE_W'(MAX_WIDTH));
	assign h_eff = effective_size(image_height, SIZE_W'(MAX_HEIGHT));

	// prediction and residual
	assign first_col = (col_q == '0);
	assign first_row = (row_q == '0);
	always_comb begin
		if (!first_col) begin
			pred = prev_q;
		end else if (!first_row) begin
			pred = row_start_q;
		end else begin
			pred = 8'd0;
		end
	end
	assign diff = $signed({1'b0, pixel_value}) - $signed({1'b0, pred});

	// halve toward zero
	assign adj  = diff + $signed({8'd0, diff[8]});
	assign half = adj >>> 1;

	// end of row and image
	assign row_end  = ({1'b0, col_q} + SIZE_W'(1)) >= w_eff;
	assign last_row = ({1'b0, row_q} + SIZE_W'(1)) >= h_eff;

	// item towards the histogram stage
	always_comb begin
		item.req = req;
		if (req == REQ_READ) begin
			item.residual  = '0;
			item.code      = '0;
			item.frame_end = 1'b0;
			item.addr      = bin_index;
		end else begin
			item.residual  = diff;
			item.code      = half[7:0] + 8'(CODE_OFFSET);
			item.frame_end = row_end && last_row;
			item.addr      = diff + BIN_W'(BIN_OFFSET);
		end
	end

	// pixel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			row_start_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (pix_accept) begin
			prev_q <= pixel_value;
			if (first_col) begin
				row_start_q <= pixel_value;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/pdch_hist.sv =====
// ----------------------------------------------------------------------------
// pdch_hist
// Residual histogram in RAM: read-modify-write with forwarding, clearing
// pass after reset, and the output register.
// ----------------------------------------------------------------------------
module pdch_hist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pdch_pkg::item_t                   item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [8:0]                 out_residual,
	output logic [7:0]                        out_code,
	output logic                              out_frame_end,
	output logic [pdch_pkg::COUNT_BITS-1:0]   out_count
);
	import pdch_pkg::*;

	logic                   accept;
	logic                   advance;

	logic                   s1_valid_q;
	item_t                  item_s1;

	logic                   clr_done_q;
	logic [BIN_W-1:0]       clr_cnt_q;

	logic                   fwd_valid_q;
	logic [BIN_W-1:0]       fwd_addr_q;
	logic [COUNT_BITS-1:0]  fwd_data_q;

	logic [COUNT_BITS-1:0]  rdata;
	logic [COUNT_BITS-1:0]  cur;
	logic [COUNT_BITS-1:0]  upd;

	logic                   we;
	logic [BIN_W-1:0]       waddr;
	logic [COUNT_BITS-1:0]  wdata;

	// handshake
	assign advance  = s1_valid_q && (!out_valid || out_ready);
	assign in_ready = clr_done_q && (!s1_valid_q || !out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	// histogram store
	pdch_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (item.addr),
		.rdata (rdata)
	);

	// forward the latest write over stale read data
	assign cur = (fwd_valid_q && (fwd_addr_q == item_s1.addr)) ? fwd_data_q : rdata;

	// saturating increment, or clear on a read request
	always_comb begin
		if (item_s1.req == REQ_READ) begin
			upd = '0;
		end else if (cur == COUNT_MAX) begin
			upd = cur;
		end else begin
			upd = cur + COUNT_BITS'(1);
		end
	end

	// write port: clearing pass first, then write-back
	always_comb begin
		if (!clr_done_q) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else begin
			we    = advance;
			waddr = item_s1.addr;
			wdata = upd;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_done_q <= 1'b0;
			clr_cnt_q  <= '0;
		end else if (!clr_done_q) begin
			clr_cnt_q <= clr_cnt_q + BIN_W'(1);
			if (clr_cnt_q == BIN_W'(RAM_DEPTH - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// last write record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clr_done_q && advance) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_done_q && advance) begin
			fwd_addr_q <= item_s1.addr;
			fwd_data_q <= upd;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_residual  <= item_s1.residual;
			out_code      <= item_s1.code;
			out_frame_end <= item_s1.frame_end;
			out_count     <= (item_s1.req == REQ_READ) ? cur : '0;
		end
	end

endmodule
